[hdl/rhh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_pkg: shared types and constants for the Robin Hood hash table
// Table geometry, slot entry layout, operation codes and the command /
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package rhh_pkg;

  // Table geometry and field widths
  localparam int SLOT_BITS   = 8;
  localparam int VALUE_WIDTH = 64;
  localparam int NSLOTS      = 1 << SLOT_BITS;
  localparam int KEY_W       = 8;
  localparam int WORD_W      = 64;
  localparam int COUNT_W     = 9;

  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [SLOT_BITS-1:0]   dist_t;
  typedef logic [SLOT_BITS:0]     cnt_t;
  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [COUNT_W-1:0]     ecount_t;

  // Operation codes
  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_SET    = 2'd1,
    FN_DELETE = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  // One slot as stored in the table memory
  typedef struct packed {
    key_t  key;
    val_t  value;
    dist_t distance;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller -> datapath commands
  typedef struct packed {
    logic load;        // capture request, start probe at home slot
    logic rd;          // read slot at probe index
    logic adv;         // step probe index, distance and step count
    logic wr_carried;  // write carried entry at probe index
    logic swap;        // carried entry takes the resident read back
    logic wr_value;    // overwrite value of the matching slot
    logic rec_hit;     // record a hit (and lookup data)
    logic del_start;   // free matching slot, open hole, start shift
    logic shift;       // move resident back into the hole
    logic set_used;    // mark probe slot used, count up
    logic set_full;    // record insert refusal
    logic out_load;    // load result register
  } rhh_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    func_t func;       // operation in progress
    logic  used_cur;   // probe slot occupied
    logic  bound;      // probe step count reached table size
    logic  closer;     // carried distance beyond resident distance
    logic  key_eq;     // resident key matches
    logic  dist_zero;  // resident sits at its home slot
    logic  full;       // occupancy at capacity
    logic  out_free;   // result register can take a beat
  } rhh_stat_t;

endpackage

[hdl/robin_hood_hash_table.sv]
`timescale 1ns / 1ps
// Sequence: accept, then for each probed slot a memory read followed by an
//   evaluate step, then load the result beat.
// Requests: one request at a time; a new request is taken only after the
//   result beat of the last one has been loaded.
// Reset: used bits and entry count clear synchronously; no clearing pass.
// ----------------------------------------------------------------------------
// robin_hood_hash_table: Robin Hood hash table with backward-shift delete
// Lookup, set and delete on an 8-bit key, one result beat per request.
// ----------------------------------------------------------------------------
module robin_hood_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_key,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [63:0] out_read_value,
  output logic        out_status,
  output logic [8:0]  out_entry_count
);

  rhh_pkg::rhh_cmd_t  cmd;
  rhh_pkg::rhh_stat_t stat;

  // Sequencer
  rhh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table storage and result register
  rhh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

[hdl/rhh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/rhh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_ctrl: operation sequencer for the Robin Hood hash table
// Walks the find, insert and backward-shift probe loops one slot at a time
// (read state, then evaluate state) and issues datapath commands.
// ----------------------------------------------------------------------------
module rhh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  rhh_pkg::rhh_stat_t stat,
  output rhh_pkg::rhh_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_FRD  = 8'b0000_0010,
    ST_FEV  = 8'b0000_0100,
    ST_IRD  = 8'b0000_1000,
    ST_IEV  = 8'b0001_0000,
    ST_DRD  = 8'b0010_0000,
    ST_DEV  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (rhh_pkg::func_t'(in_func) == rhh_pkg::FN_NOP) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_FRD;
          end
        end
      end
      ST_FRD: begin
        if (stat.bound || !stat.used_cur) begin
          // miss: gap or probe limit
          if (stat.func == rhh_pkg::FN_SET) begin
            if (stat.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = ST_DONE;
            end else begin
              state_nxt = ST_IRD;
            end
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_FEV;
        end
      end
      ST_FEV: begin
        if (stat.closer) begin
          // miss: resident is closer to home than the probe
          if (stat.func == rhh_pkg::FN_SET) begin
            if (stat.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = ST_DONE;
            end else begin
              state_nxt = ST_IRD;
            end
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (stat.key_eq) begin
          cmd.rec_hit = 1'b1;
          case (stat.func)
            rhh_pkg::FN_SET: begin
              cmd.wr_value = 1'b1;
              state_nxt    = ST_DONE;
            end
            rhh_pkg::FN_DELETE: begin
              cmd.del_start = 1'b1;
              state_nxt     = ST_DRD;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_FRD;
        end
      end
      ST_IRD: begin
        if (!stat.used_cur) begin
          cmd.wr_carried = 1'b1;
          cmd.set_used   = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_IEV;
        end
      end
      ST_IEV: begin
        // displace a richer resident, then keep probing
        if (stat.closer) begin
          cmd.wr_carried = 1'b1;
          cmd.swap       = 1'b1;
        end
        cmd.adv   = 1'b1;
        state_nxt = ST_IRD;
      end
      ST_DRD: begin
        if (stat.bound || !stat.used_cur) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_DEV;
        end
      end
      ST_DEV: begin
        if (stat.dist_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.shift = 1'b1;
          state_nxt = ST_DRD;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/rhh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_dp: datapath of the Robin Hood hash table
// Slot memory, used bits, occupancy, probe registers, carried entry and
// the result register of the output channel.
// ----------------------------------------------------------------------------
module rhh_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rhh_pkg::rhh_cmd_t  cmd,
  output rhh_pkg::rhh_stat_t stat,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_key,
  input  logic [63:0]        in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [63:0]        out_read_value,
  output logic               out_status,
  output logic [8:0]         out_entry_count
);

  // Control state
  logic [rhh_pkg::NSLOTS-1:0] used_r, used_nxt;
  rhh_pkg::cnt_t              occ_r, occ_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Probe and operation registers
  rhh_pkg::func_t op_r, op_nxt;
  rhh_pkg::slot_t idx_r, idx_nxt;
  rhh_pkg::slot_t hole_r, hole_nxt;
  rhh_pkg::cnt_t  n_r, n_nxt;
  rhh_pkg::key_t  ck_r, ck_nxt;
  rhh_pkg::val_t  cv_r, cv_nxt;
  rhh_pkg::dist_t cd_r, cd_nxt;
  logic           found_r, found_nxt;
  rhh_pkg::val_t  rv_r, rv_nxt;
  logic           st_r, st_nxt;

  // Result register
  logic            out_found_r, out_found_nxt;
  rhh_pkg::word_t  out_rv_r, out_rv_nxt;
  logic            out_st_r, out_st_nxt;
  rhh_pkg::ecount_t out_cnt_r, out_cnt_nxt;

  // Memory ports
  logic                          ram_we;
  rhh_pkg::slot_t                ram_waddr;
  logic [rhh_pkg::ENTRY_W-1:0]   ram_rdata;
  rhh_pkg::entry_t               rd_ent;
  rhh_pkg::entry_t               wr_ent;

  rhh_ram #(
    .WIDTH (rhh_pkg::ENTRY_W),
    .DEPTH (rhh_pkg::NSLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_ent = rhh_pkg::entry_t'(ram_rdata);

  // Slot write: carried entry, value overwrite or backward shift
  always_comb begin
    ram_we    = cmd.wr_carried | cmd.wr_value | cmd.shift;
    ram_waddr = cmd.shift ? hole_r : idx_r;
    if (cmd.shift) begin
      wr_ent.key      = rd_ent.key;
      wr_ent.value    = rd_ent.value;
      wr_ent.distance = rhh_pkg::dist_t'(rd_ent.distance - 1'b1);
    end else if (cmd.wr_value) begin
      wr_ent.key      = rd_ent.key;
      wr_ent.value    = cv_r;
      wr_ent.distance = rd_ent.distance;
    end else begin
      wr_ent.key      = ck_r;
      wr_ent.value    = cv_r;
      wr_ent.distance = cd_r;
    end
  end

  // Status to the controller
  always_comb begin
    stat.func      = op_r;
    stat.used_cur  = used_r[idx_r];
    stat.bound     = (n_r == rhh_pkg::cnt_t'(rhh_pkg::NSLOTS));
    stat.closer    = (cd_r > rd_ent.distance);
    stat.key_eq    = (rd_ent.key == ck_r);
    stat.dist_zero = (rd_ent.distance == '0);
    stat.full      = (occ_r == rhh_pkg::cnt_t'(rhh_pkg::NSLOTS));
    stat.out_free  = !out_valid_r || out_ready;
  end

  // Next-state logic
  always_comb begin
    used_nxt      = used_r;
    occ_nxt       = occ_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    hole_nxt      = hole_r;
    n_nxt         = n_r;
    ck_nxt        = ck_r;
    cv_nxt        = cv_r;
    cd_nxt        = cd_r;
    found_nxt     = found_r;
    rv_nxt        = rv_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_rv_nxt    = out_rv_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;

    // new request
    if (cmd.load) begin
      op_nxt    = rhh_pkg::func_t'(in_func);
      ck_nxt    = in_key;
      cv_nxt    = rhh_pkg::val_t'(in_value);
      cd_nxt    = '0;
      idx_nxt   = rhh_pkg::slot_t'(in_key);
      n_nxt     = '0;
      found_nxt = 1'b0;
      rv_nxt    = '0;
      st_nxt    = 1'b0;
    end

    // probe step (insert may pick up the displaced resident)
    if (cmd.swap) begin
      ck_nxt = rd_ent.key;
      cv_nxt = rd_ent.value;
    end
    if (cmd.adv) begin
      idx_nxt = idx_r + 1'b1;
      n_nxt   = n_r + 1'b1;
      cd_nxt  = (cmd.swap ? rd_ent.distance : cd_r) + 1'b1;
    end

    // hit bookkeeping
    if (cmd.rec_hit) begin
      found_nxt = 1'b1;
      if (op_r == rhh_pkg::FN_LOOKUP) begin
        rv_nxt = rd_ent.value;
      end
    end
    if (cmd.set_full) begin
      st_nxt = 1'b1;
    end

    // insert into a free slot
    if (cmd.set_used) begin
      used_nxt[idx_r] = 1'b1;
      occ_nxt         = occ_r + 1'b1;
    end

    // delete: free slot, hole follows the shifted entries
    if (cmd.del_start) begin
      used_nxt[idx_r] = 1'b0;
      occ_nxt         = occ_r - 1'b1;
      hole_nxt        = idx_r;
      idx_nxt         = idx_r + 1'b1;
      n_nxt           = '0;
    end
    if (cmd.shift) begin
      used_nxt[hole_r] = 1'b1;
      used_nxt[idx_r]  = 1'b0;
      hole_nxt         = idx_r;
      idx_nxt          = idx_r + 1'b1;
      n_nxt            = n_r + 1'b1;
    end

    // result beat
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_r;
      out_rv_nxt    = rhh_pkg::word_t'(rv_r);
      out_st_nxt    = st_r;
      out_cnt_nxt   = rhh_pkg::ecount_t'(occ_r);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    hole_r      <= hole_nxt;
    n_r         <= n_nxt;
    ck_r        <= ck_nxt;
    cv_r        <= cv_nxt;
    cd_r        <= cd_nxt;
    found_r     <= found_nxt;
    rv_r        <= rv_nxt;
    st_r        <= st_nxt;
    out_found_r <= out_found_nxt;
    out_rv_r    <= out_rv_nxt;
    out_st_r    <= out_st_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_read_value  = out_rv_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_cnt_r;

endmodule
